### sv/gdsf_pkg.sv
// types and constants for the greedy dual size frequency cache
// used by every module of the block; no dependencies
package gdsf_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int FRAC_BITS_DEF = 32;
  localparam int IDX_W         = $clog2(ENTRIES_DEF);
  localparam int PRIO_W        = 64;
  localparam int CAP_W         = 40;
  localparam int CFG_IDX_W     = 1;
  localparam int CNT_W         = 7;
  localparam int Q536_W        = 23;   // a 32-bit size over 536 fits here
  localparam logic [31:0] PACKET_BYTES = 32'd536;

  // size / 536 = (size >> 3) / 67, taken as (size >> 3) * RECIP_67 >> RECIP_SHIFT
  // exact for every 29-bit operand
  localparam int          RECIP_SHIFT = 36;
  localparam logic [29:0] RECIP_67    = 30'd1025663832;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'b1;

  typedef enum logic [1:0] {
    MODE_GD   = 2'd0,
    MODE_GDS  = 2'd1,
    MODE_GDSF = 2'd2,
    MODE_PKT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_FILL,
    WR_CLEAR
  } wr_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SGO,
    S_SCAN,
    S_EVAL,
    S_PGO,
    S_MUL,
    S_TGO,
    S_TWAIT,
    S_ADD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] object_id;
    logic [31:0] object_size;
  } in_data_t;

  typedef struct packed {
    logic             hit;
    logic             admitted;
    logic             rejected;
    logic [CNT_W-1:0] evicted_count;
  } out_data_t;

  // write command broadcast to the row of cells
  typedef struct packed {
    wr_op_t             op;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        id;
    logic [31:0]        size;
    logic [PRIO_W-1:0]  prio;
    logic [31:0]        freq;
    logic [31:0]        order;
  } wr_t;

  // running scan result handed from cell to cell
  typedef struct packed {
    logic               match_found;
    logic [IDX_W-1:0]   match_idx;
    logic [31:0]        match_freq;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               b1_valid;
    logic [PRIO_W-1:0]  b1_prio;
    logic [31:0]        b1_age;
    logic [31:0]        b1_size;
    logic [IDX_W-1:0]   b1_idx;
    logic               b2_valid;
    logic [31:0]        b2_age;
    logic [31:0]        b2_size;
    logic [IDX_W-1:0]   b2_idx;
  } carry_t;

endpackage

### sv/gdsf_cell.sv
// one cache slot: holds an entry and folds it into the scan carry each cycle
// depends on gdsf_pkg
module gdsf_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gdsf_pkg::wr_t   wr,
  input  logic [31:0]     order_cnt,
  input  gdsf_pkg::carry_t carry_in,
  input  logic            tok_in,
  output gdsf_pkg::carry_t carry_out,
  output logic            tok_out
);

  logic                        valid_r;
  logic [31:0]                 id_r;
  logic [31:0]                 size_r;
  logic [gdsf_pkg::PRIO_W-1:0] prio_r;
  logic [31:0]                 freq_r;
  logic [31:0]                 order_r;
  gdsf_pkg::carry_t            carry_r, carry_nxt;
  logic                        tok_r;
  logic [31:0]                 age;
  logic                        sel;

  assign sel = (wr.idx == gdsf_pkg::IDX_W'(CELL_IDX));
  assign age = order_cnt - order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (sel && wr.op == gdsf_pkg::WR_FILL) valid_r <= 1'b1;
      else if (sel && wr.op == gdsf_pkg::WR_CLEAR) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (sel && wr.op == gdsf_pkg::WR_FILL) begin
      id_r    <= wr.id;
      size_r  <= wr.size;
      prio_r  <= wr.prio;
      freq_r  <= wr.freq;
      order_r <= wr.order;
    end
  end

  always_comb begin
    carry_nxt = carry_in;
    if (valid_r) begin
      if (!carry_in.match_found && id_r == wr.id && size_r == wr.size) begin
        carry_nxt.match_found = 1'b1;
        carry_nxt.match_idx   = gdsf_pkg::IDX_W'(CELL_IDX);
        carry_nxt.match_freq  = freq_r;
      end
      if (!carry_in.b1_valid || prio_r < carry_in.b1_prio) begin
        carry_nxt.b1_valid = 1'b1;
        carry_nxt.b1_prio  = prio_r;
        carry_nxt.b1_age   = age;
        carry_nxt.b1_size  = size_r;
        carry_nxt.b1_idx   = gdsf_pkg::IDX_W'(CELL_IDX);
        carry_nxt.b2_valid = 1'b0;
      end else if (prio_r == carry_in.b1_prio) begin
        if (age > carry_in.b1_age) begin
          // old minimum becomes the runner-up
          carry_nxt.b2_valid = 1'b1;
          carry_nxt.b2_age   = carry_in.b1_age;
          carry_nxt.b2_size  = carry_in.b1_size;
          carry_nxt.b2_idx   = carry_in.b1_idx;
          carry_nxt.b1_age   = age;
          carry_nxt.b1_size  = size_r;
          carry_nxt.b1_idx   = gdsf_pkg::IDX_W'(CELL_IDX);
        end else if (!carry_in.b2_valid || age > carry_in.b2_age) begin
          carry_nxt.b2_valid = 1'b1;
          carry_nxt.b2_age   = age;
          carry_nxt.b2_size  = size_r;
          carry_nxt.b2_idx   = gdsf_pkg::IDX_W'(CELL_IDX);
        end
      end
    end else if (!carry_in.free_found) begin
      carry_nxt.free_found = 1'b1;
      carry_nxt.free_idx   = gdsf_pkg::IDX_W'(CELL_IDX);
    end
  end

  assign carry_out = carry_r;
  assign tok_out   = tok_r;

endmodule

### sv/gdsf_div.sv
// bit-serial restoring divider: floor(num * 2^FRAC_BITS / den) or floor(num / den),
// saturated to 64 bits; depends on gdsf_pkg
module gdsf_div #(
  parameter int FRAC_BITS = gdsf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        frac,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  localparam int STEPS  = 64 + FRAC_BITS;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic [63:0]       sh_r, q_r;
  logic [31:0]       rem_r;
  logic              sat_r, busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [32:0]       trial;
  logic              ge;

  assign trial = {rem_r, sh_r[63]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= num;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
      cnt_r <= frac ? STEP_W'(STEPS) : STEP_W'(64);
    end else if (busy_r) begin
      sh_r  <= {sh_r[62:0], 1'b0};
      rem_r <= ge ? 32'(trial - {1'b0, den}) : trial[31:0];
      sat_r <= sat_r | q_r[63];
      q_r   <= {q_r[62:0], ge};
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quo  = sat_r ? '1 : q_r;

endmodule

### sv/gdsf_ctrl.sv
// request sequencer: scan control, eviction loop, priority arithmetic, config
// depends on gdsf_pkg and gdsf_div
module gdsf_ctrl #(
  parameter int FRAC_BITS = gdsf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gdsf_pkg::in_data_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gdsf_pkg::out_data_t            out_data,
  input  logic                           cfg_we,
  input  logic [gdsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdsf_pkg::CAP_W-1:0]     cfg_wdata,
  output gdsf_pkg::wr_t                  wr,
  output logic [31:0]                    order_cnt,
  output logic                           scan_start,
  input  logic                           scan_done,
  input  gdsf_pkg::carry_t               scan_res
);

  gdsf_pkg::state_t              state_r, state_nxt;
  gdsf_pkg::in_data_t            req_r;
  gdsf_pkg::carry_t              res_r;
  gdsf_pkg::mode_t               mode_r;
  logic [gdsf_pkg::CAP_W-1:0]    cap_r, used_r, used_nxt;
  logic [gdsf_pkg::PRIO_W-1:0]   infl_r, infl_nxt;
  logic [31:0]                   cnt_r;
  logic [gdsf_pkg::CNT_W-1:0]    evc_r, evc_nxt;
  logic                          hit_r, hit_nxt, adm_r, adm_nxt, rej_r, rej_nxt;
  logic [gdsf_pkg::IDX_W-1:0]    slot_r, slot_nxt;
  logic [31:0]                   freq_r, freq_nxt;
  logic [gdsf_pkg::Q536_W-1:0]   q536_r;
  logic [63:0]                   num_r, num_nxt, term_r, term_nxt;
  gdsf_pkg::out_data_t           out_r;
  logic                          out_valid_r;

  logic        div_start, div_frac, div_done;
  logic [63:0] div_num, div_quo;
  logic [31:0] div_den, dsize;
  logic [64:0] prio_sum;
  logic [40:0] need;
  logic [58:0] q536_prod;
  logic        v_b2;
  logic [gdsf_pkg::IDX_W-1:0] v_idx;
  logic [31:0] v_size;
  gdsf_pkg::state_t calc_state;

  assign dsize    = (req_r.object_size == 32'd0) ? 32'd1 : req_r.object_size;
  assign need     = {1'b0, used_r} + 41'(req_r.object_size);
  assign v_b2     = res_r.b2_valid && (res_r.b2_size > res_r.b1_size);
  assign v_idx    = v_b2 ? res_r.b2_idx : res_r.b1_idx;
  assign v_size   = v_b2 ? res_r.b2_size : res_r.b1_size;
  assign prio_sum = {1'b0, infl_r} + {1'b0, term_r};
  assign q536_prod = {30'd0, req_r.object_size[31:3]} * {29'd0, gdsf_pkg::RECIP_67};

  gdsf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .frac  (div_frac),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign div_start = (state_r == gdsf_pkg::S_TGO);
  assign div_frac  = (state_r == gdsf_pkg::S_TGO);
  assign div_num   = num_r;
  assign div_den   = dsize;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdsf_pkg::S_IDLE;
      mode_r      <= gdsf_pkg::MODE_GDSF;
      cap_r       <= gdsf_pkg::CAP_W'(1048576);
      used_r      <= '0;
      infl_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      infl_r  <= infl_nxt;
      if (state_r == gdsf_pkg::S_ADD) cnt_r <= cnt_r + 32'd1;
      if (cfg_we && cfg_index == gdsf_pkg::CFG_POLICY_MODE)
        mode_r <= gdsf_pkg::mode_t'(cfg_wdata[1:0]);
      if (cfg_we && cfg_index == gdsf_pkg::CFG_CAPACITY)
        cap_r <= cfg_wdata;
      if (state_r == gdsf_pkg::S_OUT && (!out_valid_r || out_ready))
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    evc_r  <= evc_nxt;
    hit_r  <= hit_nxt;
    adm_r  <= adm_nxt;
    rej_r  <= rej_nxt;
    slot_r <= slot_nxt;
    freq_r <= freq_nxt;
    num_r  <= num_nxt;
    term_r <= term_nxt;
    if (in_valid && in_ready) req_r <= in_data;
    if (scan_done) res_r <= scan_res;
    if (state_r == gdsf_pkg::S_PGO)
      q536_r <= q536_prod[gdsf_pkg::RECIP_SHIFT +: gdsf_pkg::Q536_W];
    if (state_r == gdsf_pkg::S_OUT && (!out_valid_r || out_ready)) begin
      out_r.hit           <= hit_r;
      out_r.admitted      <= adm_r;
      out_r.rejected      <= rej_r;
      out_r.evicted_count <= evc_r;
    end
  end

  // where the term computation starts for the current mode
  always_comb begin
    unique case (mode_r)
      gdsf_pkg::MODE_GD:  calc_state = gdsf_pkg::S_ADD;
      gdsf_pkg::MODE_PKT: calc_state = gdsf_pkg::S_PGO;
      default:            calc_state = gdsf_pkg::S_TGO;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    infl_nxt   = infl_r;
    evc_nxt    = evc_r;
    hit_nxt    = hit_r;
    adm_nxt    = adm_r;
    rej_nxt    = rej_r;
    slot_nxt   = slot_r;
    freq_nxt   = freq_r;
    num_nxt    = num_r;
    term_nxt   = term_r;
    scan_start = 1'b0;
    wr         = '0;
    wr.op      = gdsf_pkg::WR_NONE;
    wr.id      = req_r.object_id;
    wr.size    = req_r.object_size;
    unique case (state_r)
      gdsf_pkg::S_IDLE: begin
        if (in_valid) begin
          evc_nxt   = '0;
          hit_nxt   = 1'b0;
          adm_nxt   = 1'b0;
          rej_nxt   = 1'b0;
          state_nxt = gdsf_pkg::S_SGO;
        end
      end
      gdsf_pkg::S_SGO: begin
        scan_start = 1'b1;
        state_nxt  = gdsf_pkg::S_SCAN;
      end
      gdsf_pkg::S_SCAN: begin
        if (scan_done) state_nxt = gdsf_pkg::S_EVAL;
      end
      gdsf_pkg::S_EVAL: begin
        if (res_r.match_found) begin
          hit_nxt  = 1'b1;
          slot_nxt = res_r.match_idx;
          freq_nxt = res_r.match_freq;
          if (mode_r[1] && res_r.match_freq != 32'hFFFF_FFFF)
            freq_nxt = res_r.match_freq + 32'd1;
          num_nxt   = (mode_r == gdsf_pkg::MODE_GDS) ? 64'd1 : 64'(freq_nxt);
          term_nxt  = 64'd1 << FRAC_BITS;
          state_nxt = calc_state;
        end else if (41'(req_r.object_size) > {1'b0, cap_r}) begin
          rej_nxt   = 1'b1;
          state_nxt = gdsf_pkg::S_OUT;
        end else if (res_r.b1_valid &&
                     (need > {1'b0, cap_r} || !res_r.free_found)) begin
          // evict the victim and scan again
          wr.op     = gdsf_pkg::WR_CLEAR;
          wr.idx    = v_idx;
          infl_nxt  = res_r.b1_prio;
          used_nxt  = used_r - gdsf_pkg::CAP_W'(v_size);
          evc_nxt   = evc_r + gdsf_pkg::CNT_W'(1);
          state_nxt = gdsf_pkg::S_SGO;
        end else if (res_r.free_found) begin
          adm_nxt   = 1'b1;
          slot_nxt  = res_r.free_idx;
          freq_nxt  = 32'd1;
          num_nxt   = (mode_r == gdsf_pkg::MODE_GDS) ? 64'd1 : 64'd1;
          term_nxt  = 64'd1 << FRAC_BITS;
          state_nxt = calc_state;
        end else begin
          state_nxt = gdsf_pkg::S_OUT;
        end
      end
      gdsf_pkg::S_PGO:   state_nxt = gdsf_pkg::S_MUL;
      gdsf_pkg::S_MUL: begin
        num_nxt   = 64'(freq_r * ({1'b0, q536_r} + 24'd2));
        state_nxt = gdsf_pkg::S_TGO;
      end
      gdsf_pkg::S_TGO:   state_nxt = gdsf_pkg::S_TWAIT;
      gdsf_pkg::S_TWAIT: begin
        if (div_done) begin
          term_nxt  = div_quo;
          state_nxt = gdsf_pkg::S_ADD;
        end
      end
      gdsf_pkg::S_ADD: begin
        wr.op    = gdsf_pkg::WR_FILL;
        wr.idx   = slot_r;
        wr.prio  = prio_sum[64] ? '1 : prio_sum[63:0];
        wr.freq  = freq_r;
        wr.order = cnt_r;
        if (adm_r) used_nxt = used_r + gdsf_pkg::CAP_W'(req_r.object_size);
        state_nxt = gdsf_pkg::S_OUT;
      end
      gdsf_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = gdsf_pkg::S_IDLE;
      end
      default: state_nxt = gdsf_pkg::S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == gdsf_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign order_cnt = cnt_r;

endmodule

### sv/greedy_dual_size_freq_cache.sv
// top level of the greedy dual size frequency cache: row of entry cells plus sequencer
// depends on gdsf_pkg, gdsf_cell, gdsf_div, gdsf_ctrl
//
//   channel | ports                          | transfer
//   request | in_valid, in_ready, in_data    | valid/ready
//   result  | out_valid, out_ready, out_data | valid/ready
//   config  | cfg_we, cfg_index, cfg_wdata   | write enable, no wait
//
// one transaction at a time. each scan of the cell row passes a start state, one register per
// cell and an evaluate state, and runs once, plus once more after every eviction. outside
// GD mode the priority term uses the serial divider; packet mode adds, before the divide,
// size/536 by reciprocal multiply and the frequency product. reset is synchronous and
// needs no clearing pass; a waiting result holds the sequencer until out_ready.
module greedy_dual_size_freq_cache #(
  parameter int FRAC_BITS = gdsf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gdsf_pkg::in_data_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gdsf_pkg::out_data_t            out_data,
  input  logic                           cfg_we,
  input  logic [gdsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdsf_pkg::CAP_W-1:0]     cfg_wdata
);

  localparam int ENTRIES = gdsf_pkg::ENTRIES_DEF;

  gdsf_pkg::wr_t    wr;
  logic [31:0]      order_cnt;
  logic             scan_start;
  gdsf_pkg::carry_t carry [ENTRIES+1];
  logic             tok   [ENTRIES+1];

  assign carry[0] = '0;
  assign tok[0]   = scan_start;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    gdsf_cell #(.CELL_IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr        (wr),
      .order_cnt (order_cnt),
      .carry_in  (carry[g]),
      .tok_in    (tok[g]),
      .carry_out (carry[g+1]),
      .tok_out   (tok[g+1])
    );
  end

  gdsf_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .wr         (wr),
    .order_cnt  (order_cnt),
    .scan_start (scan_start),
    .scan_done  (tok[ENTRIES]),
    .scan_res   (carry[ENTRIES])
  );

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for greedy_dual_size_freq_cache: directed table, then random phases
// holds its own priority-cache predictor; depends on gdsf_pkg and the block's rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int FRAC = 32;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  gdsf_pkg::in_data_t in_data;
  gdsf_pkg::out_data_t out_data;
  logic cfg_we;
  logic [gdsf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gdsf_pkg::CAP_W-1:0] cfg_wdata;

  greedy_dual_size_freq_cache dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic        slot_live [SLOTS];
  logic [31:0] slot_id [SLOTS];
  logic [31:0] slot_size [SLOTS];
  logic [63:0] slot_prio [SLOTS];
  logic [31:0] slot_freq [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [63:0] inflation;
  logic [39:0] bytes_held;
  logic [31:0] stamp_counter;
  gdsf_pkg::mode_t cur_mode;
  logic [39:0] cur_capacity;

  gdsf_pkg::out_data_t expected_results[$];
  int errors = 0;
  int rx_style = 0;   // 0 no stalls, 1 random stalls, 2 long hold-off
  bit hold_done = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < FRAC; i++) begin
      if (q > (ALL_ONES - 64'd1) / 64'd2) return ALL_ONES;
      q = q * 2;
      r = r * 2;
      if (r >= den) begin
        q = q + 1;
        r = r - den;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] priority_for(logic [31:0] size, logic [31:0] freq);
    logic [63:0] d, term, s;
    d = (size == 0) ? 64'd1 : {32'd0, size};
    case (cur_mode)
      gdsf_pkg::MODE_GD:   term = 64'd1 << FRAC;
      gdsf_pkg::MODE_GDS:  term = scaled_quotient(64'd1, d);
      gdsf_pkg::MODE_GDSF: term = scaled_quotient({32'd0, freq}, d);
      default:
        term = scaled_quotient({32'd0, freq} *
                               (64'd2 + {32'd0, size / gdsf_pkg::PACKET_BYTES}), d);
    endcase
    s = inflation + term;
    return (s < inflation) ? ALL_ONES : s;
  endfunction

  function automatic bit evict_lowest();
    int first, second;
    first = -1;
    second = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_live[i]) continue;
      if (first < 0 || slot_prio[i] < slot_prio[first] ||
          (slot_prio[i] == slot_prio[first] &&
           (stamp_counter - slot_stamp[i]) > (stamp_counter - slot_stamp[first])))
        first = i;
    end
    if (first < 0) return 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_live[i] || i == first || slot_prio[i] != slot_prio[first]) continue;
      if (second < 0 || (stamp_counter - slot_stamp[i]) > (stamp_counter - slot_stamp[second]))
        second = i;
    end
    if (second >= 0 && slot_size[second] > slot_size[first]) first = second;
    inflation = slot_prio[first];
    bytes_held = bytes_held - {8'd0, slot_size[first]};
    slot_live[first] = 0;
    return 1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < SLOTS; i++)
      if (!slot_live[i]) return i;
    return -1;
  endfunction

  function automatic gdsf_pkg::out_data_t predict_request(logic [31:0] id, logic [31:0] size);
    gdsf_pkg::out_data_t r;
    int slot, evicted;
    r = '0;
    slot = -1;
    evicted = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && slot_live[i] && slot_id[i] == id && slot_size[i] == size) slot = i;
    if (slot >= 0) begin
      r.hit = 1;
      if (cur_mode inside {gdsf_pkg::MODE_GDSF, gdsf_pkg::MODE_PKT} &&
          slot_freq[slot] != 32'hFFFF_FFFF)
        slot_freq[slot] = slot_freq[slot] + 1;
      slot_prio[slot] = priority_for(size, slot_freq[slot]);
      slot_stamp[slot] = stamp_counter;
      stamp_counter = stamp_counter + 1;
    end else if ({8'd0, size} > cur_capacity) begin
      r.rejected = 1;
    end else begin
      while ({1'b0, bytes_held} + {9'd0, size} > {1'b0, cur_capacity} && evict_lowest())
        evicted++;
      slot = first_free();
      if (slot < 0) begin
        if (evict_lowest()) evicted++;
        slot = first_free();
      end
      if (slot >= 0) begin
        r.admitted = 1;
        slot_live[slot] = 1;
        slot_id[slot] = id;
        slot_size[slot] = size;
        slot_freq[slot] = 1;
        slot_prio[slot] = priority_for(size, 32'd1);
        slot_stamp[slot] = stamp_counter;
        stamp_counter = stamp_counter + 1;
        bytes_held = bytes_held + {8'd0, size};
      end
    end
    r.evicted_count = evicted[gdsf_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        gdsf_pkg::out_data_t e;
        e = expected_results.pop_front();
        if (out_data.hit !== e.hit) report_mismatch("hit", out_data.hit, e.hit);
        if (out_data.admitted !== e.admitted)
          report_mismatch("admitted", out_data.admitted, e.admitted);
        if (out_data.rejected !== e.rejected)
          report_mismatch("rejected", out_data.rejected, e.rejected);
        if (out_data.evicted_count !== e.evicted_count)
          report_mismatch("evicted_count", out_data.evicted_count, e.evicted_count);
      end
    end
  end

  // receiver stall pattern
  initial begin
    int hold;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (rx_style == 2 && !hold_done) begin
        out_ready <= 0;
        for (hold = 0; hold < 3000; hold++) @(posedge clk);
        hold_done = 1;
        out_ready <= 1;
      end else if (rx_style == 1) begin
        out_ready <= ($urandom_range(0, 9) > 3);
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic send_request(logic [31:0] id, logic [31:0] size, bit known,
                              gdsf_pkg::out_data_t want);
    gdsf_pkg::out_data_t pred;
    in_data <= '{object_id: id, object_size: size};
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    pred = predict_request(id, size);
    if (known && pred !== want) report_mismatch("table row vs predictor", pred, want);
    expected_results.push_back(pred);
  endtask

  task automatic random_gap();
    int g;
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      g = $urandom_range(1, 12);
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [gdsf_pkg::CFG_IDX_W-1:0] idx,
                           logic [gdsf_pkg::CAP_W-1:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == gdsf_pkg::CFG_POLICY_MODE) cur_mode = gdsf_pkg::mode_t'(value[1:0]);
    else cur_capacity = value;
  endtask

  typedef struct {
    logic [31:0]         id;
    logic [31:0]         size;
    bit                  known;
    gdsf_pkg::out_data_t want;
  } table_row_t;

  typedef struct {
    gdsf_pkg::mode_t mode;
    logic [39:0]     capacity;
    int              pool;
    logic [31:0]     size_lo;
    logic [31:0]     size_hi;
    int              count;
    int              rx;
  } phase_t;

  initial begin
    table_row_t rows[$];
    phase_t phases[$];
    logic [31:0] pool_id[];
    logic [31:0] pool_sz[];
    logic [31:0] id, size;
    int k;

    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 0;
      slot_id[i] = 0;
      slot_size[i] = 0;
      slot_prio[i] = 0;
      slot_freq[i] = 0;
      slot_stamp[i] = 0;
    end
    inflation = 0;
    bytes_held = 0;
    stamp_counter = 0;
    cur_mode = gdsf_pkg::MODE_GDSF;
    cur_capacity = 40'd1048576;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed rows after reset (gdsf, 1 MiB)
    rows.push_back('{32'd0, 32'd1, 1, '{1'b0, 1'b1, 1'b0, 7'd0}});
    rows.push_back('{32'd0, 32'd1, 1, '{1'b1, 1'b0, 1'b0, 7'd0}});
    rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{1'b0, 1'b0, 1'b1, 7'd0}});
    rows.push_back('{32'hFFFF_FFFF, 32'd1048577, 1, '{1'b0, 1'b0, 1'b1, 7'd0}});
    rows.push_back('{32'd0, 32'd2, 1, '{1'b0, 1'b1, 1'b0, 7'd0}});
    rows.push_back('{32'd7, 32'd0, 1, '{1'b0, 1'b1, 1'b0, 7'd0}});   // zero size
    rows.push_back('{32'd7, 32'd0, 1, '{1'b1, 1'b0, 1'b0, 7'd0}});
    rows.push_back('{32'hFFFF_FFFF, 32'd536, 0, '0});
    rows.push_back('{32'd0, 32'd1, 0, '0});
    rows.push_back('{32'hAAAA_5555, 32'd1048576, 0, '0});   // fills whole capacity
    rows.push_back('{32'h5555_AAAA, 32'd1, 0, '0});
    rows.push_back('{32'h5555_AAAA, 32'd1, 0, '0});
    rows.push_back('{32'h1234_5678, 32'd524288, 0, '0});
    rows.push_back('{32'h1234_5679, 32'd524288, 0, '0});   // evicts the other half-capacity entry
    rows.push_back('{32'h1234_5679, 32'd524288, 0, '0});
    foreach (rows[i]) begin
      send_request(rows[i].id, rows[i].size, rows[i].known, rows[i].want);
      random_gap();
    end
    wait_drained();

    phases.push_back('{gdsf_pkg::MODE_GDSF, 40'd1048576, 90, 32'd1, 32'd64, 300, 1});
    phases.push_back('{gdsf_pkg::MODE_PKT, 40'd5000, 40, 32'd1, 32'd2000, 250, 2});
    phases.push_back('{gdsf_pkg::MODE_GD, 40'd3000, 30, 32'd1, 32'd1200, 250, 1});
    phases.push_back('{gdsf_pkg::MODE_GDS, 40'hFF_FFFF_FFFF, 80, 32'd1, 32'hFFFF_FFFF,
                       200, 0});
    phases.push_back('{gdsf_pkg::MODE_PKT, 40'd0, 4, 32'd0, 32'd3, 40, 1});
    phases.push_back('{gdsf_pkg::MODE_GDSF, 40'd100000, 50, 32'd1, 32'd20000, 150, 1});
    phases.push_back('{gdsf_pkg::MODE_GDSF, 40'd8000, 50, 32'd1, 32'd4000, 200, 0});  // shrunk
    phases.push_back('{gdsf_pkg::MODE_PKT, 40'd1048576, 60, 32'd1, 32'd70000, 150, 1});

    foreach (phases[p]) begin
      write_reg(gdsf_pkg::CFG_POLICY_MODE, {38'd0, phases[p].mode});
      write_reg(gdsf_pkg::CFG_CAPACITY, phases[p].capacity);
      rx_style = phases[p].rx;
      pool_id = new[phases[p].pool];
      pool_sz = new[phases[p].pool];
      foreach (pool_id[i]) begin
        pool_id[i] = $urandom;
        pool_sz[i] = $urandom_range(phases[p].size_hi, phases[p].size_lo);
      end
      for (int n = 0; n < phases[p].count; n++) begin
        k = $urandom_range(0, 99);
        if (k < 85) begin
          k = $urandom_range(0, phases[p].pool - 1);
          id = pool_id[k];
          size = pool_sz[k];
        end else if (k < 97) begin
          id = $urandom;
          size = $urandom_range(phases[p].size_hi, phases[p].size_lo);
        end else begin
          id = $urandom;
          size = $urandom;   // mostly oversized
        end
        send_request(id, size, 0, '0);
        if (n % 60 < 40) random_gap();   // bursts with back-to-back stretches
      end
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // a result still queued at the end keeps wait_drained waiting until the watchdog reports CHECK FAILED
endmodule
